// ----- rtl/cct_pkg.sv -----
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types and constants of the chunked cover fetch tracker.
// ----------------------------------------------------------------------------
package cct_pkg;

  // Largest cover size that is still fetched, and the request size cap
  localparam logic [32:0] MaxCoverBytes = 33'd65536;
  localparam logic [15:0] ChunkBytes    = 16'd512;

  // Item kinds
  typedef enum logic [1:0] {
    ACT_ANNOUNCE = 2'd0,
    ACT_PLAY     = 2'd1,
    ACT_DATA     = 2'd2,
    ACT_QUERY    = 2'd3
  } action_e;

  // Configuration register indexes
  localparam logic CfgStoppedCode     = 1'b0;
  localparam logic CfgHighestPlayCode = 1'b1;

  // Reset values of the configuration registers
  localparam logic [7:0] StoppedCodeReset     = 8'd0;
  localparam logic [7:0] HighestPlayCodeReset = 8'd2;

  typedef struct packed {
    logic [7:0] stopped_code;
    logic [7:0] highest_play_code;
  } cfg_t;

  typedef struct packed {
    action_e     action;
    logic [31:0] cover_bytes;
    logic [7:0]  cover_type;
    logic [31:0] cover_digest;
    logic [7:0]  play_code;
    logic [31:0] chunk_offset;
    logic [15:0] chunk_length;
    logic        frame_short;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        request_valid;
    logic [31:0] request_offset;
    logic [15:0] request_length;
    logic [31:0] data_offset;
    logic [15:0] data_length;
    logic        complete;
    logic [7:0]  image_kind;
    logic [31:0] announce_count;
  } out_item_t;

endpackage

// ----- rtl/cct_core.sv -----
// ----------------------------------------------------------------------------
// cct_core
// Tracker state and the per-transaction update; one per cycle while fire_i is high.
// ----------------------------------------------------------------------------
module cct_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  cct_pkg::in_item_t item_i,
  input  cct_pkg::cfg_t     cfg_i,
  output cct_pkg::out_item_t result_o
);
  import cct_pkg::*;

  logic [31:0] total_size_q, total_size_d;
  logic [7:0]  kind_code_q, kind_code_d;
  logic [31:0] current_hash_q, current_hash_d;
  logic [31:0] received_q, received_d;
  logic [31:0] finished_hash_q, finished_hash_d;
  logic        held_q, held_d;
  logic [31:0] revision_q, revision_d;

  logic [32:0] chunk_end;
  logic [31:0] left_bytes;
  logic        data_ok;
  logic        want_chunk;

  assign chunk_end  = {1'b0, item_i.chunk_offset} + {17'd0, item_i.chunk_length};
  assign left_bytes = total_size_q - received_q;

  // Data chunk must land exactly at the progress and stay within the size
  assign data_ok = !item_i.frame_short && (item_i.chunk_offset == received_q) &&
                   (item_i.chunk_length != 16'd0) &&
                   (chunk_end <= {1'b0, total_size_q});

  assign want_chunk = (total_size_q != 32'd0) &&
                      ({1'b0, total_size_q} <= MaxCoverBytes) &&
                      !held_q && (current_hash_q != finished_hash_q) &&
                      (received_q < total_size_q);

  // Compute next state and the result
  always_comb begin
    total_size_d    = total_size_q;
    kind_code_d     = kind_code_q;
    current_hash_d  = current_hash_q;
    received_d      = received_q;
    finished_hash_d = finished_hash_q;
    held_d          = held_q;
    revision_d      = revision_q;
    result_o        = '0;
    case (item_i.action)
      ACT_ANNOUNCE: begin
        total_size_d      = item_i.cover_bytes;
        kind_code_d       = item_i.cover_type;
        current_hash_d    = item_i.cover_digest;
        received_d        = 32'd0;
        held_d            = 1'b0;
        revision_d        = revision_q + 32'd1;
        result_o.accepted = 1'b1;
      end
      ACT_PLAY: begin
        if (item_i.play_code <= cfg_i.highest_play_code) begin
          held_d = (item_i.play_code == cfg_i.stopped_code);
          if (held_d) begin
            received_d      = 32'd0;
            finished_hash_d = 32'd0;
          end
          result_o.accepted = 1'b1;
        end
      end
      ACT_DATA: begin
        if (data_ok) begin
          received_d           = chunk_end[31:0];
          result_o.accepted    = 1'b1;
          result_o.data_offset = item_i.chunk_offset;
          result_o.data_length = item_i.chunk_length;
          if (chunk_end[31:0] == total_size_q) begin
            result_o.complete = 1'b1;
            finished_hash_d   = current_hash_q;
          end
        end
      end
      default: begin
        result_o.accepted = 1'b1;
        if (want_chunk) begin
          result_o.request_valid  = 1'b1;
          result_o.request_offset = received_q;
          result_o.request_length = (left_bytes < {16'd0, ChunkBytes}) ?
                                    left_bytes[15:0] : ChunkBytes;
        end
      end
    endcase
    result_o.image_kind     = kind_code_d;
    result_o.announce_count = revision_d;
  end

  // Commit state when the transaction leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_size_q    <= '0;
      kind_code_q     <= '0;
      current_hash_q  <= '0;
      received_q      <= '0;
      finished_hash_q <= '0;
      held_q          <= 1'b0;
      revision_q      <= '0;
    end else if (fire_i) begin
      total_size_q    <= total_size_d;
      kind_code_q     <= kind_code_d;
      current_hash_q  <= current_hash_d;
      received_q      <= received_d;
      finished_hash_q <= finished_hash_d;
      held_q          <= held_d;
      revision_q      <= revision_d;
    end
  end

endmodule

// ----- rtl/cct_out_buf.sv -----
// ----------------------------------------------------------------------------
// cct_out_buf
// Two-entry result buffer; holds up to two results while the receiver stalls.
// ----------------------------------------------------------------------------
module cct_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  cct_pkg::out_item_t push_item_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cct_pkg::out_item_t out_item_o
);
  import cct_pkg::*;

  out_item_t   mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic        pop;
  logic        push;

  assign out_valid_o = (count_q != 2'd0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (count_q != 2'd2) || pop;
  assign push        = push_i && room_o;

  // Store results
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/chunked_cover_fetch_tracker.sv -----
// ----------------------------------------------------------------------------
// chunked_cover_fetch_tracker
// Tracks an in-order chunked fetch of a cover image.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries announcements,
//   play state events, data chunk headers and queries. Every transaction gives
//   exactly one result on the output channel (out_valid_o / out_stall_i /
//   out_item_o), in order.
//   An accepted transaction is held in an input register, updates the tracker
//   state and lands in the result buffer, from which its result is offered.
//   Throughput: one transaction per cycle while the result buffer has room,
//   set by the state update between the input register and the two-entry
//   result buffer.
//   When the receiver stalls, the buffer absorbs two results and the input
//   register one more; then in_stall_o rises until a result is taken.
//   Configuration (cfg_we_i, cfg_index_i, cfg_data_i) must be written by the
//   user only while idle; the block itself does not enforce this. Index 0 is
//   the stop code, index 1 the highest valid play code.
//   Reset clears all tracker state and sets the configuration to its defaults
//   (stop code 0, highest play code 2); both channels come up empty.
// ----------------------------------------------------------------------------
module chunked_cover_fetch_tracker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cct_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cct_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [7:0]         cfg_data_i
);
  import cct_pkg::*;

  cfg_t      cfg_q;
  logic      s1_valid_q;
  in_item_t  s1_item_q;
  out_item_t result;
  logic      room;
  logic      fire;

  assign fire       = s1_valid_q && room;
  assign in_stall_o = s1_valid_q && !room;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stopped_code      <= StoppedCodeReset;
      cfg_q.highest_play_code <= HighestPlayCodeReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgStoppedCode:     cfg_q.stopped_code      <= cfg_data_i;
        CfgHighestPlayCode: cfg_q.highest_play_code <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Hold the incoming transaction in the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_item_q <= in_item_i;
    end
  end

  cct_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (s1_item_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  cct_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q),
    .push_item_i (result),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
